>>> rtl/ppr_pkg.sv
// ----------------------------------------------------------------------------
// ppr_pkg
// Shared types, codes and constants of the ping-pong responder.
// ----------------------------------------------------------------------------
package ppr_pkg;

    localparam int DEF_CACHE_ENTRIES = 8;

    // event kinds
    localparam logic [1:0] REQ_BUTTON = 2'd0;
    localparam logic [1:0] REQ_PACKET = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    // packet type bytes
    localparam logic [7:0] KIND_PING = 8'h50;
    localparam logic [7:0] KIND_PONG = 8'h60;

    localparam logic [23:0] BROADCAST_ID = 24'hFFFFFF;
    localparam logic [15:0] MAX_U16      = 16'hFFFF;

    // result actions
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_PING    = 3'd1;
    localparam logic [2:0] ACT_PONG    = 3'd2;
    localparam logic [2:0] ACT_MATCH   = 3'd3;
    localparam logic [2:0] ACT_TIMEOUT = 3'd4;

    // register map
    localparam int         APB_ADDR_W       = 4;
    localparam logic [1:0] REG_OWN_ID       = 2'd0;
    localparam logic [1:0] REG_REPLY_TMO    = 2'd1;
    localparam logic [1:0] REG_DEDUP_WINDOW = 2'd2;

    localparam logic [15:0] RST_REPLY_TMO    = 16'd1000;
    localparam logic [15:0] RST_DEDUP_WINDOW = 16'd10000;

    // cache entry layout: source, sequence, time stamp
    localparam int ENTRY_W = 24 + 16 + 32;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [7:0]         pkt_kind;
        logic [23:0]        pkt_source;
        logic [23:0]        pkt_dest;
        logic [15:0]        pkt_sequence;
        logic signed [7:0]  pkt_peer_rssi;
        logic signed [7:0]  pkt_peer_snr;
        logic signed [7:0]  meas_rssi;
        logic signed [7:0]  meas_snr;
    } t_in_word;

    typedef struct packed {
        logic [2:0]         action;
        logic [7:0]         out_kind;
        logic [23:0]        out_dest;
        logic [15:0]        out_sequence;
        logic signed [7:0]  out_rssi;
        logic signed [7:0]  out_snr;
        logic [15:0]        round_trip_ms;
        logic [15:0]        pings_sent;
        logic [15:0]        pongs_matched;
        logic [15:0]        timeouts_seen;
        logic [15:0]        replies_sent;
    } t_out_word;

    typedef struct packed {
        logic [23:0] own_id;
        logic [15:0] reply_timeout_ms;
        logic [15:0] dedup_window_ms;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic start;
        logic scan_rd;
        logic commit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_scan;
        logic scan_last;
        logic out_free;
    } t_status;

endpackage

>>> rtl/ppr_ram.sv
// ----------------------------------------------------------------------------
// ppr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ppr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/ppr_cfg.sv
// ----------------------------------------------------------------------------
// ppr_cfg
// APB register file: own ID, reply timeout and dedup window.
// ----------------------------------------------------------------------------
module ppr_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ppr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output ppr_pkg::t_cfg                 o_cfg
);

    logic [23:0] r_own_id;
    logic [15:0] r_reply_tmo;
    logic [15:0] r_dedup_window;
    logic        w_wr;
    logic [1:0]  w_idx;

    assign w_wr  = psel & penable & pwrite;
    assign w_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id       <= '0;
            r_reply_tmo    <= ppr_pkg::RST_REPLY_TMO;
            r_dedup_window <= ppr_pkg::RST_DEDUP_WINDOW;
        end else if (w_wr) begin
            case (w_idx)
                ppr_pkg::REG_OWN_ID:       r_own_id       <= pwdata[23:0];
                ppr_pkg::REG_REPLY_TMO:    r_reply_tmo    <= pwdata[15:0];
                ppr_pkg::REG_DEDUP_WINDOW: r_dedup_window <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            ppr_pkg::REG_OWN_ID:       prdata = {8'd0, r_own_id};
            ppr_pkg::REG_REPLY_TMO:    prdata = {16'd0, r_reply_tmo};
            ppr_pkg::REG_DEDUP_WINDOW: prdata = {16'd0, r_dedup_window};
            default:                   prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    assign o_cfg.own_id           = r_own_id;
    assign o_cfg.reply_timeout_ms = r_reply_tmo;
    assign o_cfg.dedup_window_ms  = r_dedup_window;

endmodule

>>> rtl/ppr_ctrl.sv
// ----------------------------------------------------------------------------
// ppr_ctrl
// Sequencer: accepts a word, runs the cache scan if needed, commits result.
// ----------------------------------------------------------------------------
module ppr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ppr_pkg::t_status i_status,
    output ppr_pkg::t_cmd    o_cmd
);

    ppr_pkg::t_state r_state;
    ppr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ppr_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state = i_status.need_scan ? ppr_pkg::ST_SCAN : ppr_pkg::ST_COMMIT;
                end
            end
            ppr_pkg::ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ppr_pkg::ST_DRAIN;
                end
            end
            // last read data is compared here
            ppr_pkg::ST_DRAIN: begin
                n_state = ppr_pkg::ST_COMMIT;
            end
            ppr_pkg::ST_COMMIT: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = ppr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ppr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/ppr_dp.sv
// ----------------------------------------------------------------------------
// ppr_dp
// Datapath: protocol state, event counters, dedup cache and output register.
// ----------------------------------------------------------------------------
module ppr_dp #(
    parameter int CACHE_ENTRIES = ppr_pkg::DEF_CACHE_ENTRIES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ppr_pkg::t_cfg      i_cfg,
    input  ppr_pkg::t_in_word  i_in_word,
    input  ppr_pkg::t_cmd      i_cmd,
    output ppr_pkg::t_status   o_status,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ppr_pkg::t_out_word o_out_word
);

    localparam int         IDX_W    = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

    ppr_pkg::t_in_word  r_in;
    ppr_pkg::t_out_word r_out_word;
    ppr_pkg::t_out_word n_out_word;
    logic               r_out_valid;

    logic               r_waiting,   n_waiting;
    logic [15:0]        r_own_seq,   n_own_seq;
    logic [15:0]        r_elapsed,   n_elapsed;
    logic [31:0]        r_ms_clock,  n_ms_clock;
    logic [15:0]        r_cnt_pings, n_cnt_pings;
    logic [15:0]        r_cnt_match, n_cnt_match;
    logic [15:0]        r_cnt_tmo,   n_cnt_tmo;
    logic [15:0]        r_cnt_reply, n_cnt_reply;
    logic               w_insert;

    logic [CACHE_ENTRIES-1:0] r_valid;
    logic [IDX_W-1:0]         r_next;
    logic [IDX_W-1:0]         r_scan_idx;
    logic [IDX_W-1:0]         r_cmp_idx;
    logic                     r_cmp_vld;
    logic                     r_dup;

    logic [ppr_pkg::ENTRY_W-1:0] w_rd_data;
    logic [23:0]                 w_rd_src;
    logic [15:0]                 w_rd_seq;
    logic [31:0]                 w_rd_stamp;
    logic [31:0]                 w_age;
    logic                        w_hit;

    // ---------------------------------------------------------------- status
    assign o_status.need_scan = (i_in_word.req_type == ppr_pkg::REQ_PACKET) && !r_waiting &&
                                (i_in_word.pkt_kind == ppr_pkg::KIND_PING) &&
                                (i_in_word.pkt_source != i_cfg.own_id);
    assign o_status.scan_last = (r_scan_idx == LAST_IDX);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    // ---------------------------------------------------------------- cache
    ppr_ram #(
        .WIDTH (ppr_pkg::ENTRY_W),
        .DEPTH (CACHE_ENTRIES)
    ) u_cache (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.commit && w_insert),
        .i_wr_addr (r_next),
        .i_wr_data ({r_in.pkt_source, r_in.pkt_sequence, r_ms_clock}),
        .i_rd_en   (i_cmd.scan_rd),
        .i_rd_addr (r_scan_idx),
        .o_rd_data (w_rd_data)
    );

    assign w_rd_src   = w_rd_data[71:48];
    assign w_rd_seq   = w_rd_data[47:32];
    assign w_rd_stamp = w_rd_data[31:0];
    assign w_age      = r_ms_clock - w_rd_stamp;
    assign w_hit      = r_cmp_vld && r_valid[r_cmp_idx] &&
                        (w_rd_src == r_in.pkt_source) &&
                        (w_rd_seq == r_in.pkt_sequence) &&
                        (w_age < {16'd0, i_cfg.dedup_window_ms});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
            r_cmp_idx  <= '0;
            r_cmp_vld  <= 1'b0;
            r_dup      <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_rd;
            r_cmp_idx <= r_scan_idx;
            if (i_cmd.start) begin
                r_scan_idx <= '0;
                r_dup      <= 1'b0;
            end else begin
                if (i_cmd.scan_rd) begin
                    r_scan_idx <= o_status.scan_last ? '0 : r_scan_idx + 1'b1;
                end
                if (w_hit) begin
                    r_dup <= 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------------- result
    always_comb begin
        n_out_word  = '0;
        n_waiting   = r_waiting;
        n_own_seq   = r_own_seq;
        n_elapsed   = r_elapsed;
        n_ms_clock  = r_ms_clock;
        n_cnt_pings = r_cnt_pings;
        n_cnt_match = r_cnt_match;
        n_cnt_tmo   = r_cnt_tmo;
        n_cnt_reply = r_cnt_reply;
        w_insert    = 1'b0;
        n_out_word.action = ppr_pkg::ACT_NONE;
        case (r_in.req_type)
            ppr_pkg::REQ_BUTTON: begin
                if (!r_waiting) begin
                    n_own_seq   = r_own_seq + 16'd1;
                    n_cnt_pings = r_cnt_pings + 16'd1;
                    n_waiting   = 1'b1;
                    n_elapsed   = '0;
                    n_out_word.action       = ppr_pkg::ACT_PING;
                    n_out_word.out_kind     = ppr_pkg::KIND_PING;
                    n_out_word.out_dest     = ppr_pkg::BROADCAST_ID;
                    n_out_word.out_sequence = n_own_seq;
                end
            end
            ppr_pkg::REQ_PACKET: begin
                if (r_waiting) begin
                    if ((r_in.pkt_kind == ppr_pkg::KIND_PONG) &&
                        (r_in.pkt_sequence == r_own_seq) &&
                        (r_in.pkt_dest == i_cfg.own_id)) begin
                        n_cnt_match = r_cnt_match + 16'd1;
                        n_waiting   = 1'b0;
                        n_out_word.action        = ppr_pkg::ACT_MATCH;
                        n_out_word.out_sequence  = r_in.pkt_sequence;
                        n_out_word.out_rssi      = r_in.pkt_peer_rssi;
                        n_out_word.out_snr       = r_in.pkt_peer_snr;
                        n_out_word.round_trip_ms = r_elapsed;
                    end
                end else if ((r_in.pkt_kind == ppr_pkg::KIND_PING) &&
                             (r_in.pkt_source != i_cfg.own_id) && !r_dup) begin
                    w_insert    = 1'b1;
                    n_cnt_reply = r_cnt_reply + 16'd1;
                    n_out_word.action       = ppr_pkg::ACT_PONG;
                    n_out_word.out_kind     = ppr_pkg::KIND_PONG;
                    n_out_word.out_dest     = r_in.pkt_source;
                    n_out_word.out_sequence = r_in.pkt_sequence;
                    n_out_word.out_rssi     = r_in.meas_rssi;
                    n_out_word.out_snr      = r_in.meas_snr;
                end
            end
            ppr_pkg::REQ_TICK: begin
                n_ms_clock = r_ms_clock + 32'd1;
                if (r_waiting) begin
                    if (r_elapsed != ppr_pkg::MAX_U16) begin
                        n_elapsed = r_elapsed + 16'd1;
                    end
                    if (n_elapsed >= i_cfg.reply_timeout_ms) begin
                        n_cnt_tmo = r_cnt_tmo + 16'd1;
                        n_waiting = 1'b0;
                        n_out_word.action       = ppr_pkg::ACT_TIMEOUT;
                        n_out_word.out_sequence = r_own_seq;
                    end
                end
            end
            default: ;
        endcase
        n_out_word.pings_sent    = n_cnt_pings;
        n_out_word.pongs_matched = n_cnt_match;
        n_out_word.timeouts_seen = n_cnt_tmo;
        n_out_word.replies_sent  = n_cnt_reply;
    end

    // ---------------------------------------------------------------- state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waiting   <= 1'b0;
            r_own_seq   <= '0;
            r_elapsed   <= '0;
            r_ms_clock  <= '0;
            r_cnt_pings <= '0;
            r_cnt_match <= '0;
            r_cnt_tmo   <= '0;
            r_cnt_reply <= '0;
            r_valid     <= '0;
            r_next      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_waiting   <= n_waiting;
                r_own_seq   <= n_own_seq;
                r_elapsed   <= n_elapsed;
                r_ms_clock  <= n_ms_clock;
                r_cnt_pings <= n_cnt_pings;
                r_cnt_match <= n_cnt_match;
                r_cnt_tmo   <= n_cnt_tmo;
                r_cnt_reply <= n_cnt_reply;
                if (w_insert) begin
                    r_valid[r_next] <= 1'b1;
                    r_next <= (r_next == LAST_IDX) ? '0 : r_next + 1'b1;
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_in <= i_in_word;
        end
        if (i_cmd.commit) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

>>> rtl/ping_pong_responder_dedup_top.sv
// ----------------------------------------------------------------------------
// ping_pong_responder_dedup_top
// Ping-pong responder with a ring cache that suppresses duplicate PINGs.
// ----------------------------------------------------------------------------
// Sequence: a button, tick or non-PING packet word goes from acceptance
//   through the commit state into the output register; a PING from another
//   node while idle first runs the cache scan (one entry per cycle through the
//   single read port of the cache RAM) and a drain state. Commit waits while
//   the output register holds an untaken result. One word is in work at a time;
//   a result may wait in the output register while the next word is taken in.
// Reset: synchronous, active low; clears protocol state, counters and cache
//   valid bits at once (no clearing pass), registers return to defaults.
module ping_pong_responder_dedup_top #(
    parameter int CACHE_ENTRIES = ppr_pkg::DEF_CACHE_ENTRIES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  ppr_pkg::t_in_word              i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output ppr_pkg::t_out_word             o_out_word,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ppr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    ppr_pkg::t_cfg    w_cfg;
    ppr_pkg::t_cmd    w_cmd;
    ppr_pkg::t_status w_status;

    ppr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ppr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    ppr_dp #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_word   (i_in_word),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // one word in flight: no second acceptance right after one
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("word accepted while previous one still in work");

    // a commit always lands in the output register
    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> o_out_valid)
        else $error("committed result not presented");

    // no cache reads or commits while the input side is open
    a_scan_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_cmd.scan_rd && !w_cmd.commit)
        else $error("scan or commit while idle");

    a_action_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.action <= ppr_pkg::ACT_TIMEOUT))
        else $error("bad action code");

endmodule
